### src/crmp_pkg.sv
// Shared widths, constants and register codes for the cosine radial mode pixel block
`default_nettype none
package crmp_pkg;

  // Field and register widths
  localparam int SIZE_W   = 11;
  localparam int INV_W    = 21;
  localparam int RLIM_W   = 24;
  localparam int MODE_W   = 8;
  localparam int COORD_W  = 10;
  localparam int VAL_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Radius path widths
  localparam int OFS_W   = 12;  // signed half-pixel offset
  localparam int DSQ_W   = 24;  // dx*dx + dy*dy
  localparam int P_W     = 45;  // D * inv_radius
  localparam int P_LO_W  = 23;  // low slice of P for the split product
  localparam int P_HI_W  = P_W - P_LO_W;
  localparam int FULL_W  = 66;  // D * inv_radius^2
  localparam int Q_W     = 58;  // square root operand below saturation
  localparam int ROOT_W  = 29;  // square root result
  localparam int R_W     = 24;  // normalised radius, Q8.16
  localparam int RAD_STAGES  = 5;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int COS_STAGES  = 11;

  // Cosine path widths and constants
  localparam int PH_W   = 17;   // phase in Q16 half-turns, modulo one full turn
  localparam int ANG_W  = 31;   // folded angle in Q30
  localparam int U2_W   = 32;
  localparam int FRAC_BITS = 15;
  localparam logic [31:0]       PI_Q30  = 32'd3373259426;
  localparam logic [ANG_W-1:0]  ONE_Q30 = 31'h4000_0000;
  // Exact reciprocals: floor(x/d) = (x*M) >> S for x below 2^N
  localparam logic [29:0] RECIP_7  = 30'd613566757;   // N = 29, S = 32
  localparam logic [31:0] RECIP_15 = 32'd2290649225;  // N = 31, S = 35
  localparam logic [30:0] RECIP_3  = 31'd1431655766;  // N = 30, S = 32

  // Configuration register codes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LIMIT = 2'd2;

  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST   = 11'd256;
  localparam logic [INV_W-1:0]  INV_RADIUS_RST   = 21'd8192;
  localparam logic [RLIM_W-1:0] RADIUS_LIMIT_RST = 24'd65536;

endpackage
`default_nettype wire

### src/crmp_radius.sv
// Offset, squared distance and scaling by the squared reciprocal radius
`default_nettype none
module crmp_radius (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [crmp_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [crmp_pkg::COORD_W-1:0]  in_column,
  input  wire logic [crmp_pkg::COORD_W-1:0]  in_row,
  input  wire logic [crmp_pkg::SIZE_W-1:0]   image_size,
  input  wire logic [crmp_pkg::INV_W-1:0]    inv_radius,
  output logic                               out_valid,
  output logic [crmp_pkg::MODE_W-1:0]        out_mode,
  output logic [crmp_pkg::Q_W-1:0]           out_q,
  output logic                               out_sat
);
  import crmp_pkg::*;

  logic [RAD_STAGES-1:0]    valid;
  logic [MODE_W-1:0]        mode [RAD_STAGES];
  logic signed [OFS_W-1:0]  dx, dy, dx_next, dy_next;
  logic signed [DSQ_W-1:0]  sqx, sqy;
  logic [DSQ_W-1:0]         dsq;
  logic [P_W-1:0]           prod;
  logic [P_HI_W+INV_W-1:0]  prod_hi;
  logic [P_LO_W+INV_W-1:0]  prod_lo;
  logic [FULL_W-1:0]        full_next;
  logic [Q_W-1:0]           q;
  logic                     sat;

  // Half-pixel offsets from the centre
  assign dx_next = $signed({1'b0, in_column, 1'b0}) - $signed({1'b0, image_size});
  assign dy_next = $signed({1'b0, in_row, 1'b0}) - $signed({1'b0, image_size});
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign full_next = (FULL_W'(prod_hi) << P_LO_W) + FULL_W'(prod_lo);

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[RAD_STAGES-2:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    mode[0] <= in_mode;
    for (int s = 1; s < RAD_STAGES; s++) begin
      mode[s] <= mode[s-1];
    end
    dx      <= dx_next;
    dy      <= dy_next;
    dsq     <= DSQ_W'($unsigned(sqx)) + DSQ_W'($unsigned(sqy));
    prod    <= P_W'(dsq) * P_W'(inv_radius);
    prod_hi <= (P_HI_W+INV_W)'(prod[P_W-1:P_LO_W]) * (P_HI_W+INV_W)'(inv_radius);
    prod_lo <= (P_LO_W+INV_W)'(prod[P_LO_W-1:0]) * (P_LO_W+INV_W)'(inv_radius);
    q       <= full_next[Q_W-1:0];
    sat     <= |full_next[FULL_W-1:Q_W];
  end

  assign out_valid = valid[RAD_STAGES-1];
  assign out_mode  = mode[RAD_STAGES-1];
  assign out_q     = q;
  assign out_sat   = sat;

endmodule
`default_nettype wire

### src/crmp_sqrt.sv
// Pipelined restoring square root, one result bit per stage, giving the Q8.16 radius
`default_nettype none
module crmp_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [crmp_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [crmp_pkg::Q_W-1:0]     in_q,
  input  wire logic                         in_sat,
  output logic                              out_valid,
  output logic [crmp_pkg::MODE_W-1:0]       out_mode,
  output logic [crmp_pkg::R_W-1:0]          out_radius
);
  import crmp_pkg::*;

  logic               valid [SQRT_STAGES+1];
  logic [MODE_W-1:0]  mode  [SQRT_STAGES+1];
  logic               sat   [SQRT_STAGES+1];
  logic [Q_W-1:0]     rem   [SQRT_STAGES+1];
  logic [ROOT_W-1:0]  root  [SQRT_STAGES+1];

  assign valid[0] = in_valid;
  assign mode[0]  = in_mode;
  assign sat[0]   = in_sat;
  assign rem[0]   = in_q;
  assign root[0]  = '0;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - j;
    logic [Q_W-1:0] trial;
    logic           take;

    // Try the next root bit against the remainder
    assign trial = (Q_W'(root[j]) << (B + 1)) | (Q_W'(1) << (2 * B));
    assign take  = rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else begin
        valid[j+1] <= valid[j];
      end
    end

    always_ff @(posedge clk) begin
      mode[j+1] <= mode[j];
      sat[j+1]  <= sat[j];
      rem[j+1]  <= take ? rem[j] - trial : rem[j];
      root[j+1] <= take ? root[j] | (ROOT_W'(1) << B) : root[j];
    end
  end

  // Drop the five extra fraction bits, or pin at the top on overflow
  assign out_valid  = valid[SQRT_STAGES];
  assign out_mode   = mode[SQRT_STAGES];
  assign out_radius = sat[SQRT_STAGES] ? {R_W{1'b1}} : root[SQRT_STAGES][ROOT_W-1:ROOT_W-R_W];

endmodule
`default_nettype wire

### src/crmp_cosine.sv
// Phase, fold and polynomial cosine in Q1.15 with the aperture mask
`default_nettype none
module crmp_cosine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [crmp_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [crmp_pkg::R_W-1:0]      in_radius,
  input  wire logic [crmp_pkg::RLIM_W-1:0]   radius_limit,
  output logic                               out_valid,
  output logic signed [crmp_pkg::VAL_W-1:0]  out_value,
  output logic                               out_inside
);
  import crmp_pkg::*;

  logic [COS_STAGES-1:0] valid;
  logic [COS_STAGES-1:0] aperture;
  logic [COS_STAGES-1:0] neg;

  logic [PH_W-1:0]       ph;
  logic [PH_W-1:0]       ph_half;
  logic [PH_W-2:0]       ph_fold;
  logic                  neg_fold;
  logic [47:0]           ang_prod;
  logic [ANG_W-1:0]      ang;
  logic [2*ANG_W-1:0]    ang_sq;
  logic [U2_W-1:0]       u2 [COS_STAGES];
  logic [58:0]           q7_prod;
  logic [26:0]           q7;
  logic [ANG_W-1:0]      coef_a;
  logic [62:0]           ta_prod;
  logic [U2_W-1:0]       ta;
  logic [62:0]           q15_prod;
  logic [27:0]           q15;
  logic [ANG_W-1:0]      coef_b;
  logic [62:0]           tb_prod;
  logic [U2_W-1:0]       tb;
  logic [60:0]           q3_prod;
  logic [28:0]           q3;
  logic [ANG_W-1:0]      coef_c1;
  logic [62:0]           tc_prod;
  logic [U2_W-1:0]       tc;
  logic [ANG_W-1:0]      half_tc;
  logic [ANG_W-1:0]      cval;
  logic [ANG_W-1:0]      rnd;
  logic [VAL_W-2:0]      mag;
  logic signed [VAL_W-1:0] value_next;
  logic signed [VAL_W-1:0] value;

  // Fold the phase into the first quarter turn, noting the sign
  always_comb begin
    ph_half  = (ph > PH_W'(17'h10000)) ? PH_W'(17'h20000) - ph : ph;
    neg_fold = ph_half > PH_W'(17'h08000);
    ph_fold  = neg_fold ? (PH_W-1)'(PH_W'(17'h10000) - ph_half) : ph_half[PH_W-2:0];
  end

  assign ang_prod = 48'(ph_fold) * 48'(PI_Q30);
  assign ang_sq   = (2*ANG_W)'(ang) * (2*ANG_W)'(ang);
  assign q7_prod  = 59'(u2[3][U2_W-1:3]) * 59'(RECIP_7);
  assign coef_a   = ONE_Q30 - ANG_W'(q7);
  assign ta_prod  = 63'(u2[4]) * 63'(coef_a);
  assign q15_prod = 63'(ta[U2_W-1:1]) * 63'(RECIP_15);
  assign coef_b   = ONE_Q30 - ANG_W'(q15);
  assign tb_prod  = 63'(u2[6]) * 63'(coef_b);
  assign q3_prod  = 61'(tb[U2_W-1:2]) * 61'(RECIP_3);
  assign coef_c1  = ONE_Q30 - ANG_W'(q3);
  assign tc_prod  = 63'(u2[8]) * 63'(coef_c1);

  // Last Horner step, clamp at zero, round half up and saturate, then apply the aperture mask and the sign
  always_comb begin
    half_tc = tc[U2_W-1:1];
    cval    = (half_tc > ONE_Q30) ? '0 : ONE_Q30 - half_tc;
    rnd     = (cval + ANG_W'(1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
    mag     = (rnd > ANG_W'((1 << FRAC_BITS) - 1)) ? {(VAL_W-1){1'b1}} : rnd[VAL_W-2:0];
    if (!aperture[9]) begin
      value_next = '0;
    end else if (neg[9]) begin
      value_next = -$signed({1'b0, mag});
    end else begin
      value_next = $signed({1'b0, mag});
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[COS_STAGES-2:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    ph          <= PH_W'(in_mode * in_radius[PH_W-1:0]);
    aperture[0] <= in_radius < radius_limit;
    neg[0]      <= 1'b0;
    for (int s = 1; s < COS_STAGES; s++) begin
      aperture[s] <= aperture[s-1];
    end
    neg[1] <= neg_fold;
    for (int s = 2; s < COS_STAGES; s++) begin
      neg[s] <= neg[s-1];
    end
    u2[0] <= '0;
    u2[1] <= '0;
    ang   <= ang_prod[46:16];
    u2[2] <= ang_sq[61:30];
    for (int s = 3; s < COS_STAGES; s++) begin
      u2[s] <= u2[s-1];
    end
    q7    <= q7_prod[58:32];
    ta    <= ta_prod[61:30];
    q15   <= q15_prod[62:35];
    tb    <= tb_prod[61:30];
    q3    <= q3_prod[60:32];
    tc    <= tc_prod[61:30];
    value <= value_next;
  end

  assign out_valid  = valid[COS_STAGES-1];
  assign out_inside = aperture[COS_STAGES-1];
  assign out_value  = value;

endmodule
`default_nettype wire

### src/cosine_radial_mode_pixel.sv
// Top level of the cosine radial mode pixel generator
//
// Pixel requests arrive on start with mode_index, column and row; a request
// transfers at a rising edge where start is high and busy is low. busy is
// always low, so a new request may be issued in every cycle.
// Each request yields exactly one result: done is high for one cycle with
// mode_value (cos(pi*k*r) in Q1.15, zero outside the aperture) and
// inside_res. The receiver cannot hold results off; results appear in
// request order.
// From the accepting edge to the cycle where done is high, a request passes
// 5 stages of offset and scaling products, 29 square root stages (one root
// bit each) and 11 cosine stages. Throughput is one pixel per cycle.
// Configuration writes transfer on cfg_valid with cfg_ready, which is always
// high; index 0 is image_size, 1 inv_radius, 2 radius_limit, 3 is ignored.
// Write them only while no request is in flight.
// Synchronous reset empties the pipeline and restores the register defaults
// (256, 8192, 65536).
`default_nettype none
module cosine_radial_mode_pixel (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [crmp_pkg::MODE_W-1:0]       mode_index,
  input  wire logic [crmp_pkg::COORD_W-1:0]      column,
  input  wire logic [crmp_pkg::COORD_W-1:0]      row,
  output logic                                   done,
  output logic signed [crmp_pkg::VAL_W-1:0]      mode_value,
  output logic                                   inside_res,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [crmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [crmp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import crmp_pkg::*;

  logic [SIZE_W-1:0] image_size;
  logic [INV_W-1:0]  inv_radius;
  logic [RLIM_W-1:0] radius_limit;

  logic              rad_valid;
  logic [MODE_W-1:0] rad_mode;
  logic [Q_W-1:0]    rad_q;
  logic              rad_sat;
  logic              sq_valid;
  logic [MODE_W-1:0] sq_mode;
  logic [R_W-1:0]    sq_radius;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size   <= IMAGE_SIZE_RST;
      inv_radius   <= INV_RADIUS_RST;
      radius_limit <= RADIUS_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_SIZE:   image_size   <= cfg_data[SIZE_W-1:0];
        CFG_INV_RADIUS:   inv_radius   <= cfg_data[INV_W-1:0];
        CFG_RADIUS_LIMIT: radius_limit <= cfg_data[RLIM_W-1:0];
        default: ;
      endcase
    end
  end

  crmp_radius u_radius (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .in_mode    (mode_index),
    .in_column  (column),
    .in_row     (row),
    .image_size (image_size),
    .inv_radius (inv_radius),
    .out_valid  (rad_valid),
    .out_mode   (rad_mode),
    .out_q      (rad_q),
    .out_sat    (rad_sat)
  );

  crmp_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rad_valid),
    .in_mode    (rad_mode),
    .in_q       (rad_q),
    .in_sat     (rad_sat),
    .out_valid  (sq_valid),
    .out_mode   (sq_mode),
    .out_radius (sq_radius)
  );

  crmp_cosine u_cosine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sq_valid),
    .in_mode      (sq_mode),
    .in_radius    (sq_radius),
    .radius_limit (radius_limit),
    .out_valid    (done),
    .out_value    (mode_value),
    .out_inside   (inside_res)
  );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the cosine radial mode pixel generator
`default_nettype none
module tb_top;
  import crmp_pkg::*;

  localparam int PIPE_LAT = 45;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    in_aperture;
  } pixel_result_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [MODE_W-1:0] mode_index;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic done;
  logic signed [VAL_W-1:0] mode_value;
  logic inside_res;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the configuration registers
  logic [SIZE_W-1:0] img_size_q;
  logic [INV_W-1:0] inv_rad_q;
  logic [RLIM_W-1:0] rad_lim_q;

  pixel_result_t expected_pixels[$];
  int fail_count = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int inside_seen = 0;
  bit steady = 0;

  cosine_radial_mode_pixel dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode_index(mode_index), .column(column), .row(row),
    .done(done), .mode_value(mode_value), .inside_res(inside_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned op, res, bitv;
    op = n;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > op) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (op >= res + bitv) begin
        op = op - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Normalised radius in Q8.16, saturated at its top
  function automatic longint unsigned pixel_radius(input longint unsigned col,
                                                   input longint unsigned rw);
    longint signed dx, dy;
    longint unsigned dsq, prod, lim, rad;
    dx = 2 * longint'(col) - longint'(img_size_q);
    dy = 2 * longint'(rw) - longint'(img_size_q);
    dsq = longint'(dx * dx) + longint'(dy * dy);
    prod = dsq * inv_rad_q;
    lim = (64'd1 << 58) - 1;
    if (prod != 0 && inv_rad_q > lim / prod) return 64'hFF_FFFF;
    rad = int_sqrt(prod * inv_rad_q) >> 5;
    return (rad > 64'hFF_FFFF) ? 64'hFF_FFFF : rad;
  endfunction

  // cos(pi*k*r) in Q1.15 through a folded Horner series
  function automatic logic signed [VAL_W-1:0] mode_cosine(input longint unsigned k,
                                                          input longint unsigned rad);
    longint unsigned ph, u, u2, a, b, c1, cu, v;
    longint signed c;
    bit neg;
    neg = 0;
    ph = (k * rad) & 64'h1_FFFF;
    if (ph > 64'h1_0000) ph = 64'h2_0000 - ph;
    if (ph > 64'h8000) begin
      ph = 64'h1_0000 - ph;
      neg = 1;
    end
    u = (ph * 64'd3373259426) >> 16;
    u2 = (u * u) >> 30;
    a = (64'd1 << 30) - u2 / 56;
    b = (64'd1 << 30) - ((u2 * a) >> 30) / 30;
    c1 = (64'd1 << 30) - ((u2 * b) >> 30) / 12;
    c = longint'(64'd1 << 30) - longint'(((u2 * c1) >> 30) / 2);
    if (c < 0) c = 0;
    cu = c;
    v = (cu + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return neg ? -VAL_W'(v) : VAL_W'(v);
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [MODE_W-1:0] k,
                                                  input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] rw);
    pixel_result_t res;
    longint unsigned rad;
    rad = pixel_radius(col, rw);
    res.in_aperture = rad < rad_lim_q;
    res.value = '0;
    if (res.in_aperture && k < 256) res.value = mode_cosine(k, rad);
    return res;
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no request outstanding: value %0d inside %0d",
               mode_value, inside_res);
        fail_count++;
      end else begin
        exp_r = expected_pixels.pop_front();
        pixels_checked++;
        if (exp_r.in_aperture) inside_seen++;
        if (mode_value !== exp_r.value) begin
          $error("mode_value: expected %0d, actual %0d", exp_r.value, mode_value);
          fail_count++;
        end
        if (inside_res !== exp_r.in_aperture) begin
          $error("inside_res: expected %0d, actual %0d", exp_r.in_aperture, inside_res);
          fail_count++;
        end
      end
    end
  end

  // Transfer one pixel request, then idle at random
  task automatic send_pixel(input logic [MODE_W-1:0] k, input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] rw);
    int gap;
    start <= 1'b1;
    mode_index <= k;
    column <= col;
    row <= rw;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(predict_pixel(k, col, rw));
    pixels_sent++;
    if (!steady && $urandom_range(99) < 14) begin
      start <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold start low and wait out every outstanding result
  task automatic drain;
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  // Transfer one register write, then release the channel
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMAGE_SIZE: begin
        img_size_q = data[SIZE_W-1:0];
      end
      CFG_INV_RADIUS: begin
        inv_rad_q = data[INV_W-1:0];
      end
      CFG_RADIUS_LIMIT: begin
        rad_lim_q = data[RLIM_W-1:0];
      end
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int size, input int inv, input int lim);
    cfg_write(CFG_IMAGE_SIZE, CFG_DATA_W'(size));
    cfg_write(CFG_INV_RADIUS, CFG_DATA_W'(inv));
    cfg_write(CFG_RADIUS_LIMIT, CFG_DATA_W'(lim));
  endtask

  // Random pixels: mostly inside the image, some anywhere in the field range
  task automatic random_pixels(input int count);
    int lim;
    lim = (img_size_q == 0) ? 1 : int'(img_size_q);
    repeat (count) begin
      if ($urandom_range(99) < 80)
        send_pixel(MODE_W'($urandom), COORD_W'($urandom_range(lim - 1)),
                   COORD_W'($urandom_range(lim - 1)));
      else
        send_pixel(MODE_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  task automatic test_reset_defaults;
    send_pixel(8'd1, 10'd128, 10'd128);
    send_pixel(8'd255, 10'd0, 10'd0);
    send_pixel(8'd0, 10'd1023, 10'd1023);
    send_pixel(8'd3, 10'd200, 10'd100);
    send_pixel(8'd255, 10'd130, 10'd140);
    drain();
  endtask

  task automatic test_directed_extremes;
    set_config(1024, 2048, 65536);
    send_pixel(8'd0, 10'd512, 10'd512);
    send_pixel(8'd1, 10'd1023, 10'd512);
    send_pixel(8'd255, 10'd0, 10'd512);
    send_pixel(8'd128, 10'd600, 10'd400);
    send_pixel(8'd170, 10'd1023, 10'd1023);
    drain();
    // Image size zero puts the centre at pixel 0; unknown register is ignored
    set_config(2048, 1048576, 16777215);
    cfg_write(CFG_UNKNOWN, 24'hFFFFFF);
    send_pixel(8'd7, 10'd0, 10'd0);
    send_pixel(8'd255, 10'd1023, 10'd1023);
    send_pixel(8'd85, 10'd1, 10'd2);
    drain();
    // Zero reciprocal radius and zero radius limit
    set_config(1, 0, 0);
    send_pixel(8'd9, 10'd0, 10'd0);
    drain();
    cfg_write(CFG_RADIUS_LIMIT, 24'd1);
    send_pixel(8'd255, 10'd1023, 10'd0);
    send_pixel(8'd0, 10'd512, 10'd1023);
    drain();
    // Saturated radius with the widest reciprocal
    set_config(1024, 2097151, 16777215);
    send_pixel(8'd255, 10'd0, 10'd0);
    send_pixel(8'd1, 10'd513, 10'd512);
    drain();
  endtask

  task automatic test_random_phases;
    int sizes[6] = '{1024, 256, 64, 1, 600, 17};
    int s;
    foreach (sizes[i]) begin
      s = sizes[i];
      steady = (i == 2);
      set_config(s + ($urandom_range(1) << 11) * (i % 2),
                 (2097152 / s) + $urandom_range(64),
                 $urandom_range(98304, 32768));
      random_pixels(70);
      drain();
    end
    steady = 0;
    // Random registers over their full range
    repeat (2) begin
      set_config($urandom, $urandom, $urandom);
      random_pixels(60);
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode_index = '0;
    column = '0;
    row = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    img_size_q = IMAGE_SIZE_RST;
    inv_rad_q = INV_RADIUS_RST;
    rad_lim_q = RADIUS_LIMIT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_phases();
    $display("covered %0d pixel requests, %0d results checked, %0d inside the aperture",
             pixels_sent, pixels_checked, inside_seen);
    $display("register sweeps included zero, minimum and maximum settings");
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
